// ===== hdl/spd_pkg.sv =====
// Package for the SSH packet deframer: phase and status codes, field widths.
// No dependencies; used by the interfaces, the parser core and the top level.
package spd_pkg;

  localparam int unsigned LenWidth  = 32;
  localparam int unsigned ByteWidth = 8;

  // Parser phase within one binary packet
  typedef enum logic [1:0] {
    PH_LEN     = 2'd0,
    PH_PADLEN  = 2'd1,
    PH_PAYLOAD = 2'd2,
    PH_PADDING = 2'd3
  } phase_t;

  // Result status codes
  typedef enum logic [2:0] {
    ST_PAYLOAD  = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_TOO_LONG = 3'd2,
    ST_ZERO     = 3'd3,
    ST_BAD_PAD  = 3'd4
  } status_t;

  // Index of the last byte of the 4-byte length field
  localparam logic [1:0] LastLenIdx = 2'd3;

endpackage

// ===== hdl/spd_ifs.sv =====
// Valid/ready channel interfaces of the SSH packet deframer.
// Depends on spd_pkg for field widths and the status type.
interface spd_byte_if import spd_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [ByteWidth-1:0] in_byte;
  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface spd_result_if import spd_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [ByteWidth-1:0] out_byte;
  logic                 out_last;
  status_t              out_status;
  modport source (output valid, output out_byte, output out_last, output out_status,
                  input ready);
  modport sink   (input valid, input out_byte, input out_last, input out_status,
                  output ready);
endinterface

interface spd_cfg_if import spd_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [LenWidth-1:0] max_frame_len;
  modport source (output valid, output max_frame_len, input ready);
  modport sink   (input valid, input max_frame_len, output ready);
endinterface

// ===== hdl/ssh_packet_deframer.sv =====
// SSH binary packet deframer, unencrypted stream: takes one byte per item and
// emits payload bytes or status results. A result appears in the result
// register in the cycle after its byte is accepted. Throughput: one byte per
// cycle unless the output stalls; the single result register lets the next
// byte in while a result is being taken. Synchronous active-high reset returns
// the parser to the first length byte and sets the length limit to 35000.
module ssh_packet_deframer import spd_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  spd_cfg_if.sink      cfg,
  spd_byte_if.sink     in_ch,
  spd_result_if.source out_ch
);

  localparam logic [LenWidth-1:0] MaxLenReset = LenWidth'(35000);

  logic [LenWidth-1:0] max_len;

  // Configuration register, writable at any cycle
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_len <= MaxLenReset;
    end else if (cfg.valid && cfg.ready) begin
      max_len <= cfg.max_frame_len;
    end
  end

  spd_core u_core (
    .clk     (clk),
    .rst     (rst),
    .max_len (max_len),
    .in_ch   (in_ch),
    .out_ch  (out_ch)
  );

endmodule

// ===== hdl/spd_core.sv =====
// Packet parser of the SSH deframer: phase state, counters and result register.
// Depends on spd_pkg and the channel interfaces in spd_ifs.sv.
module spd_core import spd_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic [LenWidth-1:0] max_len,
  spd_byte_if.sink            in_ch,
  spd_result_if.source        out_ch
);

  phase_t                 phase, phase_next;
  logic [1:0]             len_idx, len_idx_next;
  logic [LenWidth-9:0]    len_acc, len_acc_next;
  logic [LenWidth-1:0]    pay_rem, pay_rem_next;
  logic [ByteWidth-1:0]   pad_rem, pad_rem_next;

  logic                   ovalid;
  logic [ByteWidth-1:0]   obyte;
  logic                   olast;
  status_t                ostatus;

  logic                   emit;
  logic [ByteWidth-1:0]   emit_byte;
  logic                   emit_last;
  status_t                emit_status;

  logic                   accept;
  logic [LenWidth-1:0]    full_len;
  logic [LenWidth-1:0]    body;
  logic [LenWidth-1:0]    pad_ext;
  logic [LenWidth-1:0]    pay_dec;
  logic [ByteWidth-1:0]   pad_dec;

  // Take a new item whenever the result register is free or being emptied
  assign in_ch.ready = !ovalid || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  assign full_len = {len_acc, in_ch.in_byte};
  assign body     = pay_rem - LenWidth'(1);
  assign pad_ext  = LenWidth'(in_ch.in_byte);
  assign pay_dec  = pay_rem - LenWidth'(1);
  assign pad_dec  = pad_rem - ByteWidth'(1);

  // Next state and result for the byte at the input
  always_comb begin
    phase_next   = phase;
    len_idx_next = len_idx;
    len_acc_next = len_acc;
    pay_rem_next = pay_rem;
    pad_rem_next = pad_rem;
    emit         = 1'b0;
    emit_byte    = '0;
    emit_last    = 1'b0;
    emit_status  = ST_PAYLOAD;
    unique case (phase)
      PH_PADLEN: begin
        if (pad_ext > body) begin
          emit         = 1'b1;
          emit_status  = ST_BAD_PAD;
          phase_next   = PH_LEN;
          pay_rem_next = '0;
          pad_rem_next = '0;
        end else begin
          pad_rem_next = in_ch.in_byte;
          pay_rem_next = body - pad_ext;
          if (body == pad_ext) begin
            emit        = 1'b1;
            emit_status = ST_EMPTY;
            phase_next  = (in_ch.in_byte != '0) ? PH_PADDING : PH_LEN;
          end else begin
            phase_next = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        emit         = 1'b1;
        emit_byte    = in_ch.in_byte;
        pay_rem_next = pay_dec;
        if (pay_dec == '0) begin
          emit_last  = 1'b1;
          phase_next = (pad_rem != '0) ? PH_PADDING : PH_LEN;
          if (pad_rem == '0) begin
            pad_rem_next = '0;
          end
        end
      end
      PH_PADDING: begin
        pad_rem_next = pad_dec;
        if (pad_dec == '0) begin
          phase_next   = PH_LEN;
          pay_rem_next = '0;
        end
      end
      PH_LEN: begin
        len_idx_next = len_idx + 2'd1;
        len_acc_next = full_len[LenWidth-9:0];
        if (len_idx == LastLenIdx) begin
          len_acc_next = '0;
          if (full_len > max_len) begin
            emit         = 1'b1;
            emit_status  = ST_TOO_LONG;
            pay_rem_next = '0;
            pad_rem_next = '0;
          end else if (full_len == '0) begin
            emit         = 1'b1;
            emit_status  = ST_ZERO;
            pay_rem_next = '0;
            pad_rem_next = '0;
          end else begin
            pay_rem_next = full_len;
            phase_next   = PH_PADLEN;
          end
        end
      end
      default: begin
        phase_next = PH_LEN;
      end
    endcase
  end

  // Parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_LEN;
      len_idx <= '0;
      len_acc <= '0;
      pay_rem <= '0;
      pad_rem <= '0;
    end else if (accept) begin
      phase   <= phase_next;
      len_idx <= len_idx_next;
      len_acc <= len_acc_next;
      pay_rem <= pay_rem_next;
      pad_rem <= pad_rem_next;
    end
  end

  // Result register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
    end else if (accept) begin
      ovalid <= emit;
    end else if (out_ch.ready) begin
      ovalid <= 1'b0;
    end
  end

  // Result register payload
  always_ff @(posedge clk) begin
    if (accept && emit) begin
      obyte   <= emit_byte;
      olast   <= emit_last;
      ostatus <= emit_status;
    end
  end

  assign out_ch.valid      = ovalid;
  assign out_ch.out_byte   = obyte;
  assign out_ch.out_last   = olast;
  assign out_ch.out_status = ostatus;

  // A partial length field only exists while gathering length bytes
  a_len_idx_phase: assert property (@(posedge clk) disable iff (rst)
    (len_idx != '0) |-> (phase == PH_LEN))
    else $error("length byte index set outside length phase");

  // Padding phase always has bytes left to skip
  a_pad_nonzero: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_PADDING) |-> (pad_rem != '0))
    else $error("padding phase with no padding left");

  // A skipped padding byte produces no result
  a_pad_silent: assert property (@(posedge clk) disable iff (rst)
    (accept && phase == PH_PADDING) |=> !out_ch.valid)
    else $error("result produced for a padding byte");

  // The last flag only rides on payload bytes
  a_last_payload: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.out_last) |-> (out_ch.out_status == ST_PAYLOAD))
    else $error("last flag on a status result");

  // Payload phase always has at least one byte due
  a_pay_nonzero: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_PAYLOAD) |-> (pay_rem != '0))
    else $error("payload phase with no payload left");

endmodule
